### rtl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types, codes and field layout for the static array list core.
// ----------------------------------------------------------------------------
package sal_pkg;

   // default number of list cells
   localparam int CAPACITY_DEF = 8;

   // field widths
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;

   // request tdata layout: value, position
   localparam int REQ_VALUE_LSB = 0;
   localparam int REQ_POS_LSB   = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_DATA_W    = ((REQ_POS_LSB + POS_W + 7) / 8) * 8;

   // response tdata layout: status, read_value, count, is_full, is_empty
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_VALUE_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_COUNT_LSB  = RSP_VALUE_LSB + VALUE_W;
   localparam int RSP_FULL_BIT   = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_EMPTY_BIT  = RSP_FULL_BIT + 1;
   localparam int RSP_DATA_W     = ((RSP_EMPTY_BIT + 1 + 7) / 8) * 8;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_INS_HEAD  = 3'd0,
      FN_INS_TAIL  = 3'd1,
      FN_INS_SORT  = 3'd2,
      FN_REM_VALUE = 3'd3,
      FN_REM_HEAD  = 3'd4,
      FN_REM_TAIL  = 3'd5,
      FN_READ      = 3'd6
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   // datapath actions chosen by the controller
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_INS_HEAD,
      ACT_INS_TAIL,
      ACT_INS_SORT,
      ACT_REM_MATCH,
      ACT_REM_HEAD,
      ACT_REM_TAIL,
      ACT_READ
   } act_type;

   // controller states
   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       exec;
      act_type    act;
      status_type status;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic found;
      logic pos_ok;
   } dp_stat_type;

endpackage

### rtl/sal_ctrl.sv
// ----------------------------------------------------------------------------
// sal_ctrl
// Handshake state machine and operation decode for the list core.
// ----------------------------------------------------------------------------
module sal_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [sal_pkg::FUNC_W-1:0] req_func,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sal_pkg::dp_stat_type  dp_stat,
   output sal_pkg::ctl_cmd_type  cmd
);
   import sal_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshake and next state
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_HOLD: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      accept = req_tvalid && req_tready;
      if (accept) begin
         state_in = S_HOLD;
      end else if (state_ff == S_HOLD && rsp_tready) begin
         state_in = S_IDLE;
      end
   end

   // operation decode against the current list state
   always_comb begin
      cmd.exec   = accept;
      cmd.act    = ACT_NONE;
      cmd.status = ST_OK;
      case (func_type'(req_func))
         FN_INS_HEAD, FN_INS_TAIL, FN_INS_SORT: begin
            if (dp_stat.full) begin
               cmd.status = ST_FULL;
            end else if (func_type'(req_func) == FN_INS_HEAD) begin
               cmd.act = ACT_INS_HEAD;
            end else if (func_type'(req_func) == FN_INS_TAIL) begin
               cmd.act = ACT_INS_TAIL;
            end else begin
               cmd.act = ACT_INS_SORT;
            end
         end
         FN_REM_VALUE: begin
            if (dp_stat.empty) begin
               cmd.status = ST_EMPTY;
            end else if (!dp_stat.found) begin
               cmd.status = ST_NOT_FOUND;
            end else begin
               cmd.act = ACT_REM_MATCH;
            end
         end
         FN_REM_HEAD: begin
            if (dp_stat.empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.act = ACT_REM_HEAD;
            end
         end
         FN_REM_TAIL: begin
            if (dp_stat.empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.act = ACT_REM_TAIL;
            end
         end
         FN_READ: begin
            if (dp_stat.empty) begin
               cmd.status = ST_EMPTY;
            end else if (!dp_stat.pos_ok) begin
               cmd.status = ST_BAD_INDEX;
            end else begin
               cmd.act = ACT_READ;
            end
         end
         default: begin
            cmd.act    = ACT_NONE;
            cmd.status = ST_OK;
         end
      endcase
   end

endmodule

### rtl/sal_datapath.sv
// ----------------------------------------------------------------------------
// sal_datapath
// Row of list cells with parallel compare and shift, fill count and the
// response register.
// ----------------------------------------------------------------------------
module sal_datapath #(
   parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sal_pkg::VALUE_W-1:0]   req_value,
   input  logic [sal_pkg::POS_W-1:0]     req_position,
   input  sal_pkg::ctl_cmd_type          cmd,
   output sal_pkg::dp_stat_type          dp_stat,
   output logic [sal_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sal_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [sal_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_is_full,
   output logic                          rsp_is_empty
);
   import sal_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // list storage and fill count
   logic [VALUE_W-1:0]  cells_ff [CAPACITY];
   logic [VALUE_W-1:0]  cells_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   // response register
   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0]  rd_ff;
   logic [VALUE_W-1:0]  rd_in;
   logic [COUNT_W-1:0]  cnt_out_ff;
   logic                full_ff;
   logic                empty_ff;

   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] stop_sort;
   logic [CAPACITY-1:0] hit;
   logic [CNT_W-1:0]    sort_idx;
   logic [CNT_W-1:0]    match_idx;
   logic [CNT_W-1:0]    ins_at;
   logic [CNT_W-1:0]    rem_at;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    cnt_in_ext;

   // per-cell compare against the request key
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i]     = CNT_W'(i) < count_ff;
         stop_sort[i] = valid[i] && !($signed(cells_ff[i]) < $signed(req_value));
         hit[i]       = valid[i] && (cells_ff[i] == req_value);
      end
   end

   // first-match encoders
   always_comb begin
      sort_idx  = count_ff;
      match_idx = count_ff;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (stop_sort[i]) begin
            sort_idx = CNT_W'(i);
         end
         if (hit[i]) begin
            match_idx = CNT_W'(i);
         end
      end
   end

   // status toward the controller
   assign pos_ext        = CMP_W'(req_position);
   assign cnt_ext        = CMP_W'(count_ff);
   assign dp_stat.empty  = (count_ff == '0);
   assign dp_stat.full   = (count_ff == CNT_W'(CAPACITY));
   assign dp_stat.found  = |hit;
   assign dp_stat.pos_ok = pos_ext < cnt_ext;

   // shift positions
   always_comb begin
      case (cmd.act)
         ACT_INS_HEAD: ins_at = '0;
         ACT_INS_SORT: ins_at = sort_idx;
         default:      ins_at = count_ff;
      endcase
      case (cmd.act)
         ACT_REM_MATCH: rem_at = match_idx;
         default:       rem_at = '0;
      endcase
   end

   // next cell contents and count
   always_comb begin
      cells_in = cells_ff;
      count_in = count_ff;
      rd_in    = '0;
      case (cmd.act)
         ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_SORT: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CNT_W'(i) == ins_at) begin
                  cells_in[i] = req_value;
               end else if (CNT_W'(i) > ins_at) begin
                  if (i > 0) begin
                     cells_in[i] = cells_ff[i - 1];
                  end
               end
            end
            count_in = count_ff + CNT_W'(1);
         end
         ACT_REM_MATCH, ACT_REM_HEAD: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CNT_W'(i) >= rem_at) begin
                  if (i + 1 < CAPACITY) begin
                     cells_in[i] = cells_ff[i + 1];
                  end
               end
            end
            count_in = count_ff - CNT_W'(1);
         end
         ACT_REM_TAIL: begin
            count_in = count_ff - CNT_W'(1);
         end
         ACT_READ: begin
            rd_in = cells_ff[pos_ext[IDX_W-1:0]];
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign cnt_in_ext = CMP_W'(count_in);

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cells_ff <= cells_in;
      end
   end

   // response payload capture
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff  <= cmd.status;
         rd_ff      <= rd_in;
         cnt_out_ff <= cnt_in_ext[COUNT_W-1:0];
         full_ff    <= (count_in == CNT_W'(CAPACITY));
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_count      = cnt_out_ff;
   assign rsp_is_full    = full_ff;
   assign rsp_is_empty   = empty_ff;

endmodule

### rtl/static_array_list_core.sv
// ----------------------------------------------------------------------------
// static_array_list_core
// Fixed-capacity packed list of signed 32-bit keys with head, tail and sorted
// insert, removals, and indexed read; one response per request.
// ----------------------------------------------------------------------------
//
//   channel | direction | tdata (lsb up)                    | tuser
//   --------+-----------+-----------------------------------+-------------
//   req_    | in        | value[31:0], position[2:0], pad   | func[2:0]
//   rsp_    | out       | status[2:0], read_value[31:0],    | -
//           |           | count[3:0], is_full, is_empty, pad|
//
//   One request per cycle unless a held response stalls: all cells compare
//   and shift in parallel in the cycle a transaction is accepted, and the
//   response is registered. The response appears the cycle after acceptance
//   and holds while rsp_tready is low; a new request is taken in the same
//   cycle the held response is taken.
//   Synchronous reset empties the list (count to zero); cell contents are
//   not cleared.
//
module static_array_list_core #(
   parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sal_pkg::REQ_DATA_W-1:0]    req_tdata,  // value, position
   input  logic [sal_pkg::FUNC_W-1:0]        req_tuser,  // func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, read_value, count, is_full, is_empty
   output logic [sal_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import sal_pkg::*;

   ctl_cmd_type         cmd;
   dp_stat_type         dp_stat;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  read_value;
   logic [COUNT_W-1:0]  count;
   logic                is_full;
   logic                is_empty;

   // handshake and decode
   sal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_stat    (dp_stat),
      .cmd        (cmd)
   );

   // list cells and response register
   sal_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_tdata[REQ_VALUE_LSB +: VALUE_W]),
      .req_position   (req_tdata[REQ_POS_LSB +: POS_W]),
      .cmd            (cmd),
      .dp_stat        (dp_stat),
      .rsp_status     (status),
      .rsp_read_value (read_value),
      .rsp_count      (count),
      .rsp_is_full    (is_full),
      .rsp_is_empty   (is_empty)
   );

   // response packing
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_STATUS_LSB +: STATUS_W] = status;
      rsp_tdata[RSP_VALUE_LSB +: VALUE_W]   = read_value;
      rsp_tdata[RSP_COUNT_LSB +: COUNT_W]   = count;
      rsp_tdata[RSP_FULL_BIT]               = is_full;
      rsp_tdata[RSP_EMPTY_BIT]              = is_empty;
   end

endmodule

### rtl/sal_checker.sv
// ----------------------------------------------------------------------------
// sal_checker
// Port-level checks for the static array list core, bound to the top level.
// ----------------------------------------------------------------------------
module sal_checker #(
   parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sal_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sal_pkg::*;

   logic [STATUS_W-1:0] chk_status;
   logic [VALUE_W-1:0]  chk_value;
   logic [COUNT_W-1:0]  chk_count;
   logic                chk_full_cap;

   assign chk_status   = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];
   assign chk_value    = rsp_tdata[RSP_VALUE_LSB +: VALUE_W];
   assign chk_count    = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];
   assign chk_full_cap = (CAPACITY > 0);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // every accepted request produces a response next cycle
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request without response");

   // a stalled response keeps its payload
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // a failed request carries a zero read value
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && chk_status != ST_OK) |-> (chk_value == '0))
      else $error("read value on failed request");

   // empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_EMPTY_BIT] && chk_full_cap) |->
         (chk_count == '0 && !rsp_tdata[RSP_FULL_BIT]))
      else $error("empty flag with nonzero count");

endmodule

bind static_array_list_core sal_checker #(
   .CAPACITY (CAPACITY)
) u_sal_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for static_array_list_core: a directed table of list
// operations, then random fill and drain traffic, checked against a local
// model of the list with random stalls on both stream channels.
// ----------------------------------------------------------------------------
module tb;
   import sal_pkg::*;

   localparam int LIST_CAP = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_ITEMS = 120;
   localparam int LONG_HOLD = 100;
   localparam int CYCLE_LIMIT = 200000;
   // operation code with no meaning, ignored by the block
   localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  count;
      logic                is_full;
      logic                is_empty;
   } list_result_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   fn;
      logic [VALUE_W-1:0]  key;
      logic [POS_W-1:0]    pos;
      logic                typed;
      list_result_type     want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // value, position
   logic [FUNC_W-1:0] req_tuser = '0;       // func
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // status, read_value, count, is_full, is_empty

   // model state of the list
   logic [VALUE_W-1:0] list_keys [LIST_CAP];
   int list_fill = 0;

   list_result_type due_responses [$];
   script_row_type script [$];
   int error_count = 0;
   int cycles = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   bit hold_req = 1'b0;

   static_array_list_core #(.CAPACITY(LIST_CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // apply one request to the model list and return its response
   function automatic list_result_type list_apply(logic [FUNC_W-1:0] fn,
                                                  logic [VALUE_W-1:0] key,
                                                  logic [POS_W-1:0] pos);
      list_result_type r;
      int slot;
      int i;
      r.status = ST_OK;
      r.read_value = '0;
      case (fn)
         FN_INS_HEAD, FN_INS_TAIL, FN_INS_SORT: begin
            if (list_fill >= LIST_CAP) begin
               r.status = ST_FULL;
            end else begin
               slot = 0;
               if (fn == FN_INS_TAIL) begin
                  slot = list_fill;
               end else if (fn == FN_INS_SORT) begin
                  // before the first key greater than or equal, signed
                  while (slot < list_fill && $signed(list_keys[slot]) < $signed(key))
                     slot++;
               end
               for (i = list_fill; i > slot; i--)
                  list_keys[i] = list_keys[i - 1];
               list_keys[slot] = key;
               list_fill++;
            end
         end
         FN_REM_VALUE, FN_REM_HEAD: begin
            if (list_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot = 0;
               if (fn == FN_REM_VALUE) begin
                  while (slot < list_fill && list_keys[slot] != key)
                     slot++;
               end
               if (slot == list_fill) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  for (i = slot; i + 1 < list_fill; i++)
                     list_keys[i] = list_keys[i + 1];
                  list_fill--;
               end
            end
         end
         FN_REM_TAIL: begin
            if (list_fill == 0) r.status = ST_EMPTY;
            else list_fill--;
         end
         FN_READ: begin
            if (list_fill == 0) r.status = ST_EMPTY;
            else if (pos >= list_fill) r.status = ST_BAD_INDEX;
            else r.read_value = list_keys[pos];
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_fill);
      r.is_full = (list_fill == LIST_CAP);
      r.is_empty = (list_fill == 0);
      return r;
   endfunction

   // one directed row, with its response typed in when typed is set
   function automatic script_row_type row(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] key,
                                          logic [POS_W-1:0] pos, logic typed,
                                          status_type status, logic [VALUE_W-1:0] rd,
                                          int count);
      script_row_type s;
      s.fn = fn;
      s.key = key;
      s.pos = pos;
      s.typed = typed;
      s.want.status = status;
      s.want.read_value = rd;
      s.want.count = COUNT_W'(count);
      s.want.is_full = (count == LIST_CAP);
      s.want.is_empty = (count == 0);
      return s;
   endfunction

   // drive one request transaction and log what it should return
   task automatic offer_request(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] key,
                                input logic [POS_W-1:0] pos, input logic typed,
                                input list_result_type want);
      logic [REQ_DATA_W-1:0] word;
      list_result_type predicted;
      // random gap on the request side
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      word = '0;
      word[REQ_VALUE_LSB +: VALUE_W] = key;
      word[REQ_POS_LSB +: POS_W] = pos;
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= fn;
      do @(posedge clock); while (!req_tready);
      predicted = list_apply(fn, key, pos);
      due_responses.push_back(typed ? want : predicted);
   endtask

   task automatic report_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // compare a response transaction with the oldest expectation
   task automatic check_response();
      list_result_type want;
      list_result_type got;
      got.status = status_type'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]);
      got.read_value = rsp_tdata[RSP_VALUE_LSB +: VALUE_W];
      got.count = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];
      got.is_full = rsp_tdata[RSP_FULL_BIT];
      got.is_empty = rsp_tdata[RSP_EMPTY_BIT];
      if (due_responses.size() == 0) begin
         $display("%0t: response expected none actual %0h", $time, rsp_tdata);
         error_count++;
      end else begin
         want = due_responses.pop_front();
         report_field("status", want.status, got.status);
         report_field("read_value", want.read_value, got.read_value);
         report_field("count", want.count, got.count);
         report_field("is_full", want.is_full, got.is_full);
         report_field("is_empty", want.is_empty, got.is_empty);
      end
   endtask

   // response side: check transactions, random stalls, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_response();
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         stall_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // request side
   initial begin
      int k;
      int counted;
      int pick;
      bit fill_phase;
      bit drained;
      logic [FUNC_W-1:0] fn;
      logic [VALUE_W-1:0] key;
      logic [POS_W-1:0] pos;
      list_result_type none;

      none = '0;
      counted = 0;
      drained = 1'b0;

      // empty list, extremes, every operation, full and not-found cases
      script.push_back(row(FN_READ,      32'h0,        3'd0, 1, ST_EMPTY,     32'h0, 0));
      script.push_back(row(FN_REM_HEAD,  32'h0,        3'd0, 1, ST_EMPTY,     32'h0, 0));
      script.push_back(row(FN_REM_TAIL,  32'h0,        3'd0, 1, ST_EMPTY,     32'h0, 0));
      script.push_back(row(FN_REM_VALUE, 32'h0,        3'd0, 1, ST_EMPTY,     32'h0, 0));
      script.push_back(row(FN_SPARE,     32'hFFFFFFFF, 3'd7, 1, ST_OK,        32'h0, 0));
      script.push_back(row(FN_INS_TAIL,  32'h7FFFFFFF, 3'd0, 1, ST_OK,        32'h0, 1));
      script.push_back(row(FN_INS_HEAD,  32'h80000000, 3'd0, 1, ST_OK,        32'h0, 2));
      script.push_back(row(FN_READ,      32'h0,        3'd0, 1, ST_OK, 32'h80000000, 2));
      script.push_back(row(FN_READ,      32'h0,        3'd1, 1, ST_OK, 32'h7FFFFFFF, 2));
      script.push_back(row(FN_READ,      32'h0,        3'd2, 1, ST_BAD_INDEX, 32'h0, 2));
      script.push_back(row(FN_READ,      32'h0,        3'd7, 1, ST_BAD_INDEX, 32'h0, 2));
      script.push_back(row(FN_INS_SORT,  32'h0,        3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_INS_SORT,  32'hFFFFFFFF, 3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_INS_SORT,  32'h0,        3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_INS_SORT,  32'h7FFFFFFF, 3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_INS_SORT,  32'h80000000, 3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_INS_TAIL,  32'h5,        3'd0, 1, ST_OK,        32'h0, 8));
      script.push_back(row(FN_INS_HEAD,  32'h1,        3'd0, 1, ST_FULL,      32'h0, 8));
      script.push_back(row(FN_INS_SORT,  32'h2,        3'd0, 1, ST_FULL,      32'h0, 8));
      script.push_back(row(FN_INS_TAIL,  32'h3,        3'd0, 1, ST_FULL,      32'h0, 8));
      script.push_back(row(FN_READ,      32'h0,        3'd7, 1, ST_OK,        32'h5, 8));
      script.push_back(row(FN_REM_VALUE, 32'd12345,    3'd0, 1, ST_NOT_FOUND, 32'h0, 8));
      script.push_back(row(FN_REM_VALUE, 32'h0,        3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_REM_HEAD,  32'h0,        3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_REM_TAIL,  32'h0,        3'd0, 0, ST_OK,        32'h0, 0));
      script.push_back(row(FN_READ,      32'h0,        3'd0, 0, ST_OK,        32'h0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < script.size(); k++)
         offer_request(script[k].fn, script[k].key, script[k].pos,
                       script[k].typed, script[k].want);

      // random part, starting under a long response hold-off
      hold_req = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         // pause until the block has answered everything
         if (!drained && counted == RANDOM_ITEMS / 2) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            while (due_responses.size() != 0) @(posedge clock);
         end
         quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
         fill_phase = ((counted / 48) % 2 == 0);

         // operation mix leans to inserts or removals by phase
         pick = $urandom_range(0, 99);
         if (pick >= 97) fn = FN_SPARE;
         else if (pick < (fill_phase ? 60 : 25)) fn = FUNC_W'($urandom_range(0, 2));
         else if (pick < (fill_phase ? 85 : 75)) fn = FUNC_W'($urandom_range(3, 5));
         else fn = FN_READ;

         // keys: a present key for value removals, small pool for duplicates, extremes, or fully random
         pick = $urandom_range(0, 99);
         if (fn == FN_REM_VALUE && list_fill > 0 && pick < 60)
            key = list_keys[$urandom_range(0, list_fill - 1)];
         else if (pick < 50) key = VALUE_W'($urandom_range(0, 7) - 4);
         else if (pick < 65)
            case ($urandom_range(0, 3))
               0: key = 32'h80000000;
               1: key = 32'h7FFFFFFF;
               2: key = 32'h0;
               default: key = 32'hFFFFFFFF;
            endcase
         else key = $urandom;

         if (fn == FN_READ && list_fill > 0 && $urandom_range(0, 9) < 7)
            pos = POS_W'($urandom_range(0, list_fill - 1));
         else pos = POS_W'($urandom_range(0, 7));

         offer_request(fn, key, pos, 1'b0, none);
         if (fn != FN_SPARE) counted++;
      end

      // drain and settle
      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/sal_pkg.sv
rtl/sal_ctrl.sv
rtl/sal_datapath.sv
rtl/static_array_list_core.sv
rtl/sal_checker.sv
tb/tb.sv
